FILE: src/bitmap_slot_table_rank_select_macros.svh
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_TABLE_RANK_SELECT_MACROS_SVH
`define BITMAP_SLOT_TABLE_RANK_SELECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSTRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSTRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bstrs_pkg.sv
// ----------------------------------------------------------------------------
// Slot table package
// Sizes, operation codes and transaction types of the slot table.
// ----------------------------------------------------------------------------
package bstrs_pkg;

  // Table geometry
  localparam int SLOT_COUNT  = 64;
  localparam int MAX_ENTRIES = 64;
  localparam int ENTRY_BITS  = 32;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
  localparam int RANK_W  = 8;
  localparam int KIND_W  = 3;

  // Wide enough for counts, ranks and the entry limit side by side
  localparam int CMP_W = ((COUNT_W > RANK_W) ? COUNT_W : RANK_W) + 1;

  // Rank-select scans the bitmap one byte per cycle (SLOT_COUNT multiple of 8)
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNK_COUNT = SLOT_COUNT / CHUNK_BITS;
  localparam int CHUNK_W     = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int POS_W       = $clog2(CHUNK_BITS);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GET        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FORMAT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ITER_BEGIN = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ITER_NEXT  = 3'd6;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Command transaction
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [RANK_W-1:0]     rank;
    logic [ENTRY_BITS-1:0] entry_in;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic                  status;
    logic [ENTRY_BITS-1:0] entry_out;
    logic [SLOT_W-1:0]     slot_used;
    logic [COUNT_W-1:0]    count_now;
  } out_t;

  // Rank-select request and response
  typedef struct packed {
    logic              go;
    logic [RANK_W-1:0] rank;
  } sel_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } sel_rsp_t;

endpackage

FILE: src/bstrs_select.sv
// ----------------------------------------------------------------------------
// Slot table rank-select unit
// Finds the set bit of a given rank in a bitmap, one byte per cycle.
// ----------------------------------------------------------------------------
module bstrs_select
  import bstrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sel_req_t              req,
  input  logic [SLOT_COUNT-1:0] map,
  output sel_rsp_t              rsp
);

  logic                    running_r;
  logic [CHUNK_W-1:0]      chunk_r;
  logic [CMP_W-1:0]        seen_r;
  logic [RANK_W-1:0]       rank_r;

  logic [CHUNK_BITS-1:0]   byte_bits;
  logic [CMP_W-1:0]        offset;
  logic [POS_W:0]          cnt;
  logic                    hit;
  logic [POS_W-1:0]        pos;
  logic                    last;

  // Search the current byte for the remaining rank
  always_comb begin
    byte_bits = map[chunk_r * CHUNK_BITS +: CHUNK_BITS];
    offset    = CMP_W'(rank_r) - seen_r;
    cnt       = '0;
    hit       = 1'b0;
    pos       = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      if (byte_bits[i]) begin
        if (!hit && (CMP_W'(cnt) == offset)) begin
          hit = 1'b1;
          pos = POS_W'(i);
        end
        cnt = cnt + 1'b1;
      end
    end
  end

  assign last = (chunk_r == CHUNK_W'(CHUNK_COUNT - 1));

  assign rsp.done  = running_r && (hit || last);
  assign rsp.found = running_r && hit;
  assign rsp.slot  = SLOT_W'({chunk_r, pos});

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else if (req.go) begin
      running_r <= 1'b1;
      chunk_r   <= '0;
      seen_r    <= '0;
      rank_r    <= req.rank;
    end else if (running_r) begin
      if (hit || last) begin
        running_r <= 1'b0;
      end else begin
        chunk_r <= chunk_r + 1'b1;
        seen_r  <= seen_r + CMP_W'(cnt);
      end
    end
  end

endmodule

FILE: src/bitmap_slot_table_rank_select.sv
// ----------------------------------------------------------------------------
// Bitmap slot table with rank-select access
// Append, get, set, delete, format and iterator commands on a slot table.
// ----------------------------------------------------------------------------
// One command is taken at a clock edge where start is high and busy is low;
// each command gives exactly one result, shown for a single cycle with
// out_valid high, which the receiver must take then. Format, iterator begin,
// unknown codes and commands rejected up front (table full, rank not below
// the entry count) give their result in the cycle after acceptance. Other
// commands go through the rank-select, which scans the occupancy bitmap
// eight slots per cycle until the slot is found; get and iterator next
// then read the entry store through its registered read port before the
// result register is loaded. busy is high from acceptance until the
// result register is loaded; a new command may be taken while a result
// is shown. The entry store needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "bitmap_slot_table_rank_select_macros.svh"

module bitmap_slot_table_rank_select
  import bstrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ
  } state_t;

  state_t                 state_r;
  logic [SLOT_COUNT-1:0]  map_r;
  logic [COUNT_W-1:0]     total_r;
  logic [RANK_W-1:0]      iter_r;
  logic [KIND_W-1:0]      kind_r;
  logic [ENTRY_BITS-1:0]  data_r;
  logic [SLOT_W-1:0]      slot_r;
  logic                   out_valid_r;
  out_t                   out_data_r;

  logic [ENTRY_BITS-1:0]  mem [SLOT_COUNT];
  logic [ENTRY_BITS-1:0]  rd_data_r;

  logic                   accept;
  logic [RANK_W-1:0]      eff_rank;
  logic                   rank_ok;
  logic                   room_ok;
  logic                   is_select;
  sel_req_t               sel_req;
  sel_rsp_t               sel_rsp;
  logic [SLOT_COUNT-1:0]  sel_map;
  logic                   mem_we;
  logic                   mem_re;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Up-front checks on the incoming command
  assign eff_rank  = (in_data.kind == KIND_ITER_NEXT) ? iter_r : in_data.rank;
  assign rank_ok   = (CMP_W'(eff_rank) < CMP_W'(total_r));
  assign room_ok   = (CMP_W'(total_r) < CMP_W'(MAX_ENTRIES));
  assign is_select = (in_data.kind == KIND_GET) || (in_data.kind == KIND_SET) ||
                     (in_data.kind == KIND_DELETE) || (in_data.kind == KIND_ITER_NEXT);

  // Append looks for the lowest free slot: rank 0 of the inverted map
  always_comb begin
    sel_req.go   = 1'b0;
    sel_req.rank = eff_rank;
    if (accept) begin
      if (in_data.kind == KIND_APPEND) begin
        sel_req.go   = room_ok;
        sel_req.rank = '0;
      end else if (is_select) begin
        sel_req.go = rank_ok;
      end
    end
  end

  assign sel_map = (kind_r == KIND_APPEND) ? ~map_r : map_r;

  bstrs_select u_select (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sel_req),
    .map   (sel_map),
    .rsp   (sel_rsp)
  );

  // Entry store access at the end of the search
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    if (state_r == ST_SEARCH && sel_rsp.done && sel_rsp.found) begin
      mem_we = (kind_r == KIND_APPEND) || (kind_r == KIND_SET);
      mem_re = (kind_r == KIND_GET) || (kind_r == KIND_ITER_NEXT);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sel_rsp.slot] <= data_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[sel_rsp.slot];
    end
  end

  // Command sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_r       <= '0;
      total_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r               <= in_data.kind;
            data_r               <= in_data.entry_in;
            out_data_r.status    <= STATUS_ERR;
            out_data_r.entry_out <= '0;
            out_data_r.slot_used <= '0;
            out_data_r.count_now <= total_r;
            if (in_data.kind == KIND_ITER_NEXT) begin
              iter_r <= iter_r + RANK_W'(1);
            end
            if (sel_req.go) begin
              state_r <= ST_SEARCH;
            end else begin
              out_valid_r <= 1'b1;
              if (in_data.kind == KIND_FORMAT) begin
                map_r                <= '0;
                total_r              <= '0;
                out_data_r.status    <= STATUS_OK;
                out_data_r.count_now <= '0;
              end else if (in_data.kind == KIND_ITER_BEGIN) begin
                iter_r            <= '0;
                out_data_r.status <= STATUS_OK;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (sel_rsp.done) begin
            slot_r <= sel_rsp.slot;
            if (!sel_rsp.found) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else if (mem_re) begin
              state_r <= ST_READ;
            end else begin
              out_valid_r          <= 1'b1;
              state_r              <= ST_IDLE;
              out_data_r.status    <= STATUS_OK;
              out_data_r.slot_used <= sel_rsp.slot;
              if (kind_r == KIND_APPEND) begin
                map_r[sel_rsp.slot]  <= 1'b1;
                total_r              <= total_r + 1'b1;
                out_data_r.count_now <= total_r + 1'b1;
              end else if (kind_r == KIND_DELETE) begin
                map_r[sel_rsp.slot]  <= 1'b0;
                total_r              <= total_r - 1'b1;
                out_data_r.count_now <= total_r - 1'b1;
              end
            end
          end
        end
        ST_READ: begin
          out_valid_r          <= 1'b1;
          state_r              <= ST_IDLE;
          out_data_r.status    <= STATUS_OK;
          out_data_r.entry_out <= rd_data_r;
          out_data_r.slot_used <= slot_r;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `BSTRS_ASSERT_SAME(a_count_matches_map, 1'b1, $countones(map_r) == int'(total_r), "entry count differs from bitmap")
  `BSTRS_ASSERT_SAME(a_count_limit, 1'b1, CMP_W'(total_r) <= CMP_W'(MAX_ENTRIES), "entry count above limit")
  `BSTRS_ASSERT_SAME(a_select_in_search, sel_rsp.done, state_r == ST_SEARCH, "rank-select finished outside search")
  `BSTRS_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid, "accepted command neither busy nor answered")

endmodule

FILE: tb/bitmap_slot_table_rank_select_tb.sv
// ----------------------------------------------------------------------------
// Slot table rank-select testbench
// Drives append, get, set, delete, format and iterator commands into the slot
// table, predicts every result from a shadow copy of the bitmap, count, store
// and iterator position, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module bitmap_slot_table_rank_select_tb
  import bstrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Code with no operation behind it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 200000;

  // One queued command with the sender behavior around it
  typedef struct {
    in_t         cmd;
    int unsigned idle_pct;
    bit          drain_first;
  } pending_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  pending_cmd_t command_queue[$];
  out_t         expected_results[$];
  bit           took_item = 1'b0;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           planned_entries = 0;

  // Shadow table state
  logic [SLOT_COUNT-1:0] occ_map = '0;
  logic [ENTRY_BITS-1:0] entry_copy [SLOT_COUNT];
  int                    entry_total = 0;
  logic [RANK_W-1:0]     iter_pos = '0;

  bitmap_slot_table_rank_select dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow table and return its result
  function automatic out_t apply_command(in_t cmd);
    out_t res;
    int   s;
    int   seen;
    int   hit;
    int   r;
    res = '0;
    res.status = STATUS_ERR;
    hit = -1;
    case (cmd.kind)
      KIND_APPEND: begin
        if (entry_total < MAX_ENTRIES) begin
          for (s = 0; s < SLOT_COUNT; s++) begin
            if (!occ_map[s] && hit < 0) hit = s;
          end
          if (hit >= 0) begin
            entry_copy[hit] = cmd.entry_in;
            occ_map[hit] = 1'b1;
            entry_total++;
            res.status = STATUS_OK;
            res.slot_used = hit[SLOT_W-1:0];
          end
        end
      end
      KIND_GET, KIND_SET, KIND_DELETE, KIND_ITER_NEXT: begin
        r = cmd.rank;
        if (cmd.kind == KIND_ITER_NEXT) begin
          r = iter_pos;
          iter_pos = iter_pos + 1'b1;
        end
        if (r < entry_total) begin
          // rank-select: r-th occupied slot counting up from slot 0
          seen = 0;
          for (s = 0; s < SLOT_COUNT; s++) begin
            if (occ_map[s]) begin
              if (seen == r && hit < 0) hit = s;
              seen++;
            end
          end
          if (hit >= 0) begin
            res.status = STATUS_OK;
            res.slot_used = hit[SLOT_W-1:0];
            if (cmd.kind == KIND_GET || cmd.kind == KIND_ITER_NEXT) begin
              res.entry_out = entry_copy[hit];
            end else if (cmd.kind == KIND_SET) begin
              entry_copy[hit] = cmd.entry_in;
            end else begin
              occ_map[hit] = 1'b0;
              entry_total--;
            end
          end
        end
      end
      KIND_FORMAT: begin
        occ_map = '0;
        entry_total = 0;
        res.status = STATUS_OK;
      end
      KIND_ITER_BEGIN: begin
        iter_pos = '0;
        res.status = STATUS_OK;
      end
      default: ;
    endcase
    res.count_now = entry_total[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Queue a command; track the entry count so ranks can aim at live entries
  task automatic queue_cmd(logic [KIND_W-1:0] kind, int rank, logic [ENTRY_BITS-1:0] data,
                           int unsigned idle_pct, bit drain_first);
    pending_cmd_t p;
    p.cmd.kind = kind;
    p.cmd.rank = rank[RANK_W-1:0];
    p.cmd.entry_in = data;
    p.idle_pct = idle_pct;
    p.drain_first = drain_first;
    command_queue.push_back(p);
    case (kind)
      KIND_APPEND: if (planned_entries < MAX_ENTRIES) planned_entries++;
      KIND_DELETE: if (rank < planned_entries) planned_entries--;
      KIND_FORMAT: planned_entries = 0;
      default: ;
    endcase
  endtask

  // Weighted kind; mode 1 leans to appends, mode 2 to deletes
  function automatic logic [KIND_W-1:0] pick_kind(int mode);
    int roll;
    roll = $urandom_range(99);
    if (mode == 1) roll = (roll < 30) ? 0 : roll;
    if (mode == 2) roll = (roll < 30) ? 60 : roll;
    if (roll < 28) return KIND_APPEND;
    if (roll < 46) return KIND_GET;
    if (roll < 60) return KIND_SET;
    if (roll < 76) return KIND_DELETE;
    if (roll < 91) return KIND_ITER_NEXT;
    if (roll < 95) return KIND_ITER_BEGIN;
    if (roll < 98) return KIND_FORMAT;
    return KIND_UNUSED;
  endfunction

  // Driver: present the next command at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (command_queue.size() == 0) begin
        start <= 1'b0;
      end else if (command_queue[0].drain_first && expected_results.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < command_queue[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        in_data <= command_queue[0].cmd;
        start <= 1'b1;
        command_queue.pop_front();
      end
    end
  end

  // Monitor: check strobed results, then record the command taken at this edge
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h", $time, out_data);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          report_field("status", exp_r.status, out_data.status);
          report_field("entry_out", exp_r.entry_out, out_data.entry_out);
          report_field("slot_used", exp_r.slot_used, out_data.slot_used);
          report_field("count_now", exp_r.count_now, out_data.count_now);
        end
      end
      if (start && busy === 1'b0) begin
        expected_results.push_back(apply_command(in_data));
        took_item <= 1'b1;
      end else begin
        took_item <= 1'b0;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_slot_table_rank_select regression: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int i;
    int idle;
    int rank;
    logic [KIND_W-1:0] kind;

    // Directed: field extremes, every operation, error paths
    queue_cmd(KIND_APPEND, 0, '0, 0, 1'b0);
    queue_cmd(KIND_APPEND, 255, '1, 0, 1'b0);
    queue_cmd(KIND_GET, 0, '0, 0, 1'b0);
    queue_cmd(KIND_GET, 1, '1, 0, 1'b0);
    queue_cmd(KIND_GET, 2, '0, 0, 1'b0);
    queue_cmd(KIND_GET, 255, '0, 0, 1'b0);
    queue_cmd(KIND_SET, 0, '1, 0, 1'b0);
    queue_cmd(KIND_SET, 5, 32'h5A5A_A5A5, 0, 1'b0);
    queue_cmd(KIND_DELETE, 0, '0, 0, 1'b0);
    queue_cmd(KIND_APPEND, 0, 32'h1234_5678, 0, 1'b0);
    queue_cmd(KIND_ITER_BEGIN, 0, '0, 0, 1'b0);
    queue_cmd(KIND_ITER_NEXT, 0, '0, 0, 1'b0);
    queue_cmd(KIND_ITER_NEXT, 0, '0, 0, 1'b0);
    queue_cmd(KIND_ITER_NEXT, 0, '0, 0, 1'b0);
    queue_cmd(KIND_DELETE, 255, '0, 0, 1'b0);
    queue_cmd(KIND_UNUSED, 255, '1, 0, 1'b0);
    queue_cmd(KIND_FORMAT, 0, '0, 0, 1'b0);
    queue_cmd(KIND_GET, 0, '0, 0, 1'b0);
    queue_cmd(KIND_DELETE, 0, '0, 0, 1'b0);
    queue_cmd(KIND_ITER_NEXT, 0, '0, 0, 1'b0);
    queue_cmd(KIND_ITER_BEGIN, 0, '0, 0, 1'b1);

    // Random: three idle phases, the second and third each opened after a full drain
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle = (i < PHASE_ITEMS) ? 0 : (i < 2 * PHASE_ITEMS) ? 59 : 10;
      // fill the table past full at the start of the run
      if (i < SLOT_COUNT + 2) begin
        queue_cmd(KIND_APPEND, $urandom_range(255), $urandom, idle, 1'b0);
      end else begin
        kind = pick_kind((i / 100) % 3);
        rank = ($urandom_range(99) < 85) ? $urandom_range(planned_entries)
                                         : $urandom_range(255);
        queue_cmd(kind, rank, $urandom, idle,
                  (i % PHASE_ITEMS == 0) || ($urandom_range(99) == 0));
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (command_queue.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("bitmap_slot_table_rank_select regression: pass");
    end else begin
      $display("bitmap_slot_table_rank_select regression: fail");
    end
    $finish;
  end

endmodule
